>>> sv/dcw_pkg.sv
// ----------------------------------------------------------------------------
// dcw_pkg: shared types and constants
// Geometry, zoom factors, instruction codes and payload structs for the
// dual-chip LCD write decoder.
// ----------------------------------------------------------------------------
package dcw_pkg;

  // display geometry and scaling
  localparam int ZOOM_H           = 2;
  localparam int ZOOM_V           = 3;
  localparam int COLUMNS_PER_CHIP = 120;
  localparam int PAGE_COUNT       = 12;
  localparam int TOTAL_COLUMNS    = 2 * COLUMNS_PER_CHIP;
  localparam int RAM_DEPTH        = TOTAL_COLUMNS * PAGE_COUNT;
  localparam int IDX_W            = $clog2(RAM_DEPTH);

  localparam int COL_W    = 8;
  localparam int PAGE_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int COORD_W  = 10;
  localparam int OFFSET_W = 9;
  localparam int BIT_W    = 3;
  localparam int CFG_IDX_W = 2;

  // bus codes
  localparam logic [BYTE_W-1:0] INSTR_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] PAGE_CMD   = 8'hB0;
  localparam logic [BYTE_W-1:0] PAGE_FIELD = 8'h0F;
  localparam logic [BYTE_W-1:0] RAM_INIT   = 8'hFF;
  localparam logic ACTION_DATA = 1'b1;
  localparam logic CHIP_LEFT   = 1'b0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;

  typedef struct packed {
    logic              chip;
    logic              action;
    logic [BYTE_W-1:0] bus_byte;
  } dcw_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               dark;
    logic               last;
  } dcw_out_t;

  // resolved data write from the page/column tracker
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [COL_W-1:0]  col;
    logic [PAGE_W-1:0] page;
  } dcw_req_t;

  // pixel run handed to the emitter
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [BYTE_W-1:0]  value;
  } dcw_run_t;

endpackage

>>> sv/dcw_shadow_ram.sv
// ----------------------------------------------------------------------------
// dcw_shadow_ram: shadow copy of display RAM
// One read port and one write port, registered read data. After reset a
// sweep writes RAM_INIT to every entry, one per cycle.
// ----------------------------------------------------------------------------
module dcw_shadow_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [dcw_pkg::IDX_W-1:0]  rd_addr,
  output logic [dcw_pkg::BYTE_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [dcw_pkg::IDX_W-1:0]  wr_addr,
  input  logic [dcw_pkg::BYTE_W-1:0] wr_data,
  output logic                       clearing
);
  import dcw_pkg::*;

  logic [BYTE_W-1:0] mem [RAM_DEPTH];
  logic              clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] rd_data_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == IDX_W'(RAM_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign mem_we    = clr_busy_r || wr_en;
  assign mem_waddr = clr_busy_r ? clr_addr_r : wr_addr;
  assign mem_wdata = clr_busy_r ? RAM_INIT : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

endmodule

>>> sv/dcw_tracker.sv
// ----------------------------------------------------------------------------
// dcw_tracker: per-chip page and column state
// Decodes page instructions, range-checks data writes, advances the column
// and forms the shadow RAM index of the addressed byte.
// ----------------------------------------------------------------------------
module dcw_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  dcw_pkg::dcw_in_t  item,
  output dcw_pkg::dcw_req_t req
);
  import dcw_pkg::*;

  logic [PAGE_W-1:0] lpage_r, lpage_nxt, rpage_r, rpage_nxt;
  logic [COL_W-1:0]  lcol_r, lcol_nxt, rcol_r, rcol_nxt;
  logic [COL_W-1:0]  cur_col;
  logic [PAGE_W-1:0] cur_page;
  logic [COL_W:0]    first;
  logic              in_range, page_ok, is_data, is_page_cmd;

  assign cur_col  = (item.chip == CHIP_LEFT) ? lcol_r : rcol_r;
  assign cur_page = (item.chip == CHIP_LEFT) ? lpage_r : rpage_r;
  assign first    = (item.chip == CHIP_LEFT) ? '0 : (COL_W+1)'(COLUMNS_PER_CHIP);
  assign in_range = ({1'b0, cur_col} >= first) &&
                    ({1'b0, cur_col} < first + (COL_W+1)'(COLUMNS_PER_CHIP));
  assign page_ok  = {1'b0, cur_page} < (PAGE_W+1)'(PAGE_COUNT);
  assign is_data  = item.action == ACTION_DATA;
  assign is_page_cmd = !is_data && ((item.bus_byte & INSTR_MASK) == PAGE_CMD);

  always_comb begin
    req.hit  = is_data && in_range && page_ok;
    req.idx  = IDX_W'(cur_col * IDX_W'(PAGE_COUNT)) + IDX_W'(cur_page);
    req.col  = cur_col;
    req.page = cur_page;
  end

  always_comb begin
    lpage_nxt = lpage_r;
    rpage_nxt = rpage_r;
    lcol_nxt  = lcol_r;
    rcol_nxt  = rcol_r;
    if (fire) begin
      if (is_page_cmd) begin
        if (item.chip == CHIP_LEFT) begin
          lpage_nxt = PAGE_W'(item.bus_byte & PAGE_FIELD);
          lcol_nxt  = '0;
        end else begin
          rpage_nxt = PAGE_W'(item.bus_byte & PAGE_FIELD);
          rcol_nxt  = COL_W'(COLUMNS_PER_CHIP);
        end
      end else if (is_data && in_range) begin
        // column moves even when the page is out of range
        if (item.chip == CHIP_LEFT) begin
          lcol_nxt = lcol_r + 1'b1;
        end else begin
          rcol_nxt = rcol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpage_r <= '0;
      rpage_r <= '0;
      lcol_r  <= '0;
      rcol_r  <= COL_W'(COLUMNS_PER_CHIP);
    end else begin
      lpage_r <= lpage_nxt;
      rpage_r <= rpage_nxt;
      lcol_r  <= lcol_nxt;
      rcol_r  <= rcol_nxt;
    end
  end

endmodule

>>> sv/dcw_emitter.sv
// ----------------------------------------------------------------------------
// dcw_emitter: pixel run serializer
// Holds one changed byte and streams its eight pixels, bit 0 first, from
// registers onto the result channel.
// ----------------------------------------------------------------------------
module dcw_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dcw_pkg::dcw_run_t run,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_stall,
  output dcw_pkg::dcw_out_t out_item
);
  import dcw_pkg::*;

  localparam logic [BIT_W-1:0] LAST_BIT = '1;

  logic               run_valid_r, run_valid_nxt;
  logic [BIT_W-1:0]   cnt_r, cnt_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [BYTE_W-1:0]  value_r, value_nxt;
  logic               out_fire;

  assign out_fire = run_valid_r && !out_stall;
  assign can_take = !run_valid_r || (out_fire && cnt_r == LAST_BIT);

  always_comb begin
    run_valid_nxt = run_valid_r;
    cnt_nxt       = cnt_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    value_nxt     = value_r;
    if (load) begin
      run_valid_nxt = 1'b1;
      cnt_nxt       = '0;
      px_nxt        = run.px;
      py_nxt        = run.py;
      value_nxt     = run.value;
    end else if (out_fire) begin
      if (cnt_r == LAST_BIT) begin
        run_valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        py_nxt  = py_r + COORD_W'(ZOOM_V);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      run_valid_r <= run_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    value_r <= value_nxt;
  end

  assign out_valid = run_valid_r;
  always_comb begin
    out_item.pixel_x = px_r;
    out_item.pixel_y = py_r;
    out_item.dark    = value_r[cnt_r];
    out_item.last    = cnt_r == LAST_BIT;
  end

endmodule

>>> sv/dual_chip_lcd_write_decoder.sv
// ----------------------------------------------------------------------------
// dual_chip_lcd_write_decoder: snooped two-chip graphic LCD write decoder
// Tracks page/column per chip, diffs data writes against a shadow RAM and
// emits eight scaled pixels for every byte that changed.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the 2880-byte shadow RAM to 0xFF, one
// byte per cycle, and holds in_stall high until the sweep is done; config
// writes are taken throughout. Instructions, out-of-range writes and data
// writes that match the shadow copy go through at one transaction per
// cycle while no changed byte is waiting on the pixel serializer; any
// data write in the compare stage waits there until the serializer can
// take a new run, and the input stalls meanwhile. A data write that
// changes a byte produces eight result transactions from the pixel
// serializer, one per cycle while out_stall is low; the serializer takes a
// new run as the last pixel of the previous one is taken, and it sets the
// sustained rate for changed bytes. The shadow RAM read is registered,
// then compare/write-back loads the serializer, whose registers drive
// the first pixel. Back-to-back writes to the same byte are handled by
// forwarding the value being written back into the next compare. Config
// (x/y offsets) must only change while the block is idle.
// ----------------------------------------------------------------------------
module dual_chip_lcd_write_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dcw_pkg::dcw_in_t              in_item,
  // pixel transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output dcw_pkg::dcw_out_t             out_item,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcw_pkg::OFFSET_W-1:0]  cfg_data
);
  import dcw_pkg::*;

  // config registers
  logic [OFFSET_W-1:0] xoff_r, xoff_nxt, yoff_r, yoff_nxt;

  // stage A: accept, track page/column, issue RAM read
  logic     a_fire;
  dcw_req_t req;

  // stage B: RAM data back, compare, write back, hand off run
  logic              b_valid_r, b_valid_nxt;
  dcw_req_t          b_req_r;
  logic [BYTE_W-1:0] b_value_r;
  logic              b_move, b_diff, b_we;
  logic [BYTE_W-1:0] b_old;

  // read-after-write forwarding for same-entry back-to-back writes
  logic              fwd_r, fwd_nxt;
  logic [BYTE_W-1:0] fwd_data_r;

  logic              ram_clearing;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              em_can_take;
  dcw_run_t          run;

  assign cfg_ready = 1'b1;

  always_comb begin
    xoff_nxt = xoff_r;
    yoff_nxt = yoff_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_OFFSET: xoff_nxt = cfg_data;
        CFG_Y_OFFSET: yoff_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xoff_r <= '0;
      yoff_r <= '0;
    end else begin
      xoff_r <= xoff_nxt;
      yoff_r <= yoff_nxt;
    end
  end

  // B may only leave when the serializer can take a run
  assign b_move   = b_valid_r && em_can_take;
  assign in_stall = ram_clearing || (b_valid_r && !em_can_take);
  assign a_fire   = in_valid && !in_stall;

  dcw_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (a_fire),
    .item  (in_item),
    .req   (req)
  );

  dcw_shadow_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (a_fire && req.hit),
    .rd_addr  (req.idx),
    .rd_data  (ram_rd_data),
    .wr_en    (b_we),
    .wr_addr  (b_req_r.idx),
    .wr_data  (b_value_r),
    .clearing (ram_clearing)
  );

  assign b_old  = fwd_r ? fwd_data_r : ram_rd_data;
  assign b_diff = b_value_r != b_old;
  assign b_we   = b_move && b_diff;

  // read issued this cycle misses the write B does this cycle: forward it
  assign fwd_nxt = b_we && (b_req_r.idx == req.idx);

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (a_fire) begin
      b_valid_nxt = req.hit;
    end else if (b_move) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (a_fire) begin
        fwd_r <= fwd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_req_r    <= req;
      b_value_r  <= in_item.bus_byte;
      fwd_data_r <= b_value_r;
    end
  end

  // scaled screen position, wraps at 1024
  always_comb begin
    run.px    = COORD_W'(32'(xoff_r) + 32'(b_req_r.col) * ZOOM_H);
    run.py    = COORD_W'(32'(yoff_r) + 32'(b_req_r.page) * 8 * ZOOM_V);
    run.value = b_value_r;
  end

  dcw_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (b_we),
    .run       (run),
    .can_take  (em_can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
